@@ hdl/tog_pkg.sv @@
package tog_pkg;

    localparam int POS_W     = 10;
    localparam int GLYPH_W   = 6;
    localparam int X0_W      = 14;
    localparam int OFFSET_W  = 26;
    localparam int DIM_W     = 13;
    localparam int MASK_W    = 10;
    localparam int ROW_W     = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = 1;
    localparam int Q_CW      = 2;

    localparam logic [POS_W-1:0]   POS_MAX        = 10'd1023;
    localparam logic [ROW_W-1:0]   LAST_ROW       = 3'd6;
    localparam logic [DIM_W-1:0]   DEFAULT_STRIDE = 13'd256;
    localparam logic [DIM_W-1:0]   DEFAULT_WIDTH  = 13'd256;
    localparam logic [DIM_W-1:0]   DEFAULT_HEIGHT = 13'd224;
    localparam logic [DIM_W-1:0]   WIDE_LIMIT     = 13'd256;
    localparam logic [DIM_W-1:0]   TALL_LIMIT     = 13'd224;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK    = 6'd34;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_BASE    = 3'd1;
    localparam logic [2:0] REG_STRIDE  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_DEFBASE = 3'd5;

    typedef struct packed {
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [7:0]  char_code;
        logic [15:0] pen_color;
        logic        first_of_string;
    } t_char;

    typedef struct packed {
        logic [31:0] span_address;
        logic [9:0]  write_mask;
        logic [15:0] span_color;
        logic        last_span;
    } t_span;

    typedef struct packed {
        logic [31:0]      base;
        logic [DIM_W-1:0] stride;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             sx;
        logic             sy;
    } t_target;

    typedef struct packed {
        logic [GLYPH_W-1:0]  glyph;
        logic [11:0]         start_y;
        logic [15:0]         color;
        logic [OFFSET_W-1:0] offset;
        logic [31:0]         base;
        logic [DIM_W-1:0]    stride;
        logic [DIM_W-1:0]    height;
        logic                sx;
        logic                sy;
        logic [MASK_W-1:0]   hmask;
    } t_job;

    localparam logic [4:0] FONT_ROM [0:34][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
    };

    // character code to font row index; unknown codes map to blank
    function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
        logic [GLYPH_W-1:0] idx;
        logic [7:0]         digit;
        digit = code - 8'h30;
        idx   = GLYPH_BLANK;
        if (code inside {[8'h30:8'h39]}) begin
            idx = digit[GLYPH_W-1:0];
        end else begin
            case (code)
                8'h41: idx = 6'd10;
                8'h42: idx = 6'd11;
                8'h43: idx = 6'd12;
                8'h44: idx = 6'd13;
                8'h45: idx = 6'd14;
                8'h46: idx = 6'd15;
                8'h47: idx = 6'd16;
                8'h49: idx = 6'd17;
                8'h4B: idx = 6'd18;
                8'h4C: idx = 6'd19;
                8'h4D: idx = 6'd20;
                8'h4E: idx = 6'd21;
                8'h4F: idx = 6'd22;
                8'h50: idx = 6'd23;
                8'h52: idx = 6'd24;
                8'h53: idx = 6'd25;
                8'h54: idx = 6'd26;
                8'h55: idx = 6'd27;
                8'h56: idx = 6'd28;
                8'h58: idx = 6'd29;
                8'h59: idx = 6'd30;
                8'h3D: idx = 6'd31;
                8'h2D: idx = 6'd32;
                8'h3E: idx = 6'd33;
                default: idx = GLYPH_BLANK;
            endcase
        end
        return idx;
    endfunction

    // glyph bit 4 is the leftmost column, mask bit 0 the leftmost pixel
    function automatic logic [MASK_W-1:0] expand_row(input logic [4:0] bits,
                                                     input logic       sx);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int c = 0; c < 5; c++) begin
            if (sx) begin
                m[2*c]   = bits[4-c];
                m[2*c+1] = bits[4-c];
            end else begin
                m[c] = bits[4-c];
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/text_overlay_glyph_rasterizer.sv @@
// Text overlay glyph rasterizer: 5x7 character generator.
// Character channel: queue-style, an item is taken on a clock edge with push
// high and full low. Span channel: the oldest span sits on o_span while empty
// is low and leaves on an edge with pop high.
// Each character yields 7 spans (14 when the target height is over 224),
// one span per clock while the receiver keeps popping, in top-to-bottom
// order; last_span marks the final one. When the block is otherwise idle, the
// first span of a character passes the job queue, then the output register,
// before it appears (empty low). The back end's row sequencer issues one span
// per cycle, while the receiver keeps up, into a single output register.
// The front end computes position, glyph index, start offset and horizontal
// clip in the cycle it takes the item and parks the job in a two-entry queue,
// so it keeps taking characters while the back end is busy or stalled.
// A stalled receiver holds the output register; the back end then stops,
// the queue fills and full rises.
// Reset (synchronous, active low) clears the config registers, the character
// position counter, the queue, the row sequencer and the output valid flag.
// Config: APB-style, registers at byte addresses 4*i; the user writes them only while idle (unenforced).
module text_overlay_glyph_rasterizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  tog_pkg::t_char i_item,
    output logic           empty,
    input  logic           pop,
    output tog_pkg::t_span o_span,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import tog_pkg::*;

    // configuration registers
    logic             r_enable;
    logic [31:0]      r_base;
    logic [DIM_W-1:0] r_stride;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [31:0]      r_defbase;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             use_custom;
    t_target          target;

    logic             accept;
    t_job             front_job;
    t_job             head_job;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_base    <= '0;
            r_stride  <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_defbase <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:  r_enable  <= pwdata[0];
                REG_BASE:    r_base    <= pwdata;
                REG_STRIDE:  r_stride  <= pwdata[DIM_W-1:0];
                REG_WIDTH:   r_width   <= pwdata[DIM_W-1:0];
                REG_HEIGHT:  r_height  <= pwdata[DIM_W-1:0];
                REG_DEFBASE: r_defbase <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:  prdata = {31'd0, r_enable};
            REG_BASE:    prdata = r_base;
            REG_STRIDE:  prdata = 32'(r_stride);
            REG_WIDTH:   prdata = 32'(r_width);
            REG_HEIGHT:  prdata = 32'(r_height);
            REG_DEFBASE: prdata = r_defbase;
            default:     prdata = '0;
        endcase
    end

    // custom target only when enabled and fully described
    always_comb begin
        use_custom    = r_enable && (r_stride != '0) && (r_width != '0) &&
                        (r_height != '0);
        target.base   = use_custom ? r_base   : r_defbase;
        target.stride = use_custom ? r_stride : DEFAULT_STRIDE;
        target.width  = use_custom ? r_width  : DEFAULT_WIDTH;
        target.height = use_custom ? r_height : DEFAULT_HEIGHT;
        target.sx     = target.width > WIDE_LIMIT;
        target.sy     = target.height > TALL_LIMIT;
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    tog_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_target (target),
        .o_job    (front_job)
    );

    tog_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tog_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_span      (o_span)
    );

endmodule

@@ hdl/tog_front.sv @@
module tog_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  tog_pkg::t_char   i_item,
    input  tog_pkg::t_target i_target,
    output tog_pkg::t_job    o_job
);
    import tog_pkg::*;

    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [POS_W-1:0]    pos;
    logic [12:0]         pos5;
    logic [X0_W-1:0]     step;
    logic [X0_W-1:0]     x0;
    logic [24:0]         yoff;
    logic [MASK_W-1:0]   hmask;
    logic [3:0]          span_w;

    always_comb begin
        pos   = i_item.first_of_string ? '0 : r_pos;
        n_pos = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
        pos5  = {1'b0, pos, 2'b00} + {3'b000, pos};
        step  = i_target.sx ? {pos5, 1'b0} : {1'b0, pos5};
        x0    = {2'b00, i_item.start_x} + step;
        yoff  = 25'(i_item.start_y) * 25'(i_target.stride);
    end

    // horizontal clip, fixed for every row of the glyph
    always_comb begin
        span_w = i_target.sx ? 4'd10 : 4'd5;
        for (int k = 0; k < MASK_W; k++) begin
            hmask[k] = (4'(k) < span_w) &&
                       (({1'b0, x0} + 15'(k)) < {2'b00, i_target.width});
        end
    end

    always_comb begin
        o_job.glyph   = glyph_index(i_item.char_code);
        o_job.start_y = i_item.start_y;
        o_job.color   = i_item.pen_color;
        o_job.offset  = OFFSET_W'(yoff) + OFFSET_W'(x0);
        o_job.base    = i_target.base;
        o_job.stride  = i_target.stride;
        o_job.height  = i_target.height;
        o_job.sx      = i_target.sx;
        o_job.sy      = i_target.sy;
        o_job.hmask   = hmask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_item.first_of_string && r_pos == POS_MAX) |=> (r_pos == POS_MAX))
        else $error("character position left saturation");
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.first_of_string) |=> (r_pos == 10'd1))
        else $error("string start did not restart position");
`endif

endmodule

@@ hdl/tog_queue.sv @@
module tog_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tog_pkg::t_job i_data,
    input  logic          i_pop,
    output tog_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import tog_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job queue underflow");
`endif

endmodule

@@ hdl/tog_back.sv @@
module tog_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tog_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output tog_pkg::t_span o_span
);
    import tog_pkg::*;

    logic [ROW_W-1:0]  r_row;
    logic              r_dy;
    logic [31:0]       r_addr;
    logic [DIM_W-1:0]  r_y;
    logic              r_out_valid;
    t_span             r_out;

    logic              emit;
    logic              first;
    logic              last;
    logic [31:0]       cur_addr;
    logic [DIM_W-1:0]  cur_y;
    logic [4:0]        row_bits;
    logic [MASK_W-1:0] mask;

    always_comb begin
        emit     = !i_job_empty && (!r_out_valid || i_pop);
        first    = (r_row == '0) && !r_dy;
        last     = (r_row == LAST_ROW) && (r_dy == i_job.sy);
        cur_addr = first ? i_job.base + 32'(i_job.offset) : r_addr;
        cur_y    = first ? {1'b0, i_job.start_y} : r_y;
        row_bits = FONT_ROM[i_job.glyph][r_row];
        mask     = (cur_y < i_job.height) ?
                   (expand_row(row_bits, i_job.sx) & i_job.hmask) : '0;
    end

    assign o_job_pop = emit && last;
    assign o_empty   = !r_out_valid;
    assign o_span    = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.span_address <= cur_addr;
            r_out.write_mask   <= mask;
            r_out.span_color   <= i_job.color;
            r_out.last_span    <= last;
            r_addr             <= cur_addr + 32'(i_job.stride);
            r_y                <= cur_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_dy        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (i_job.sy && !r_dy) begin
                    r_dy <= 1'b1;
                end else begin
                    r_dy  <= 1'b0;
                    r_row <= last ? '0 : r_row + 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= LAST_ROW)
        else $error("glyph row counter out of range");
    a_dy_needs_tall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dy |-> (!i_job_empty && i_job.sy))
        else $error("second scaled row without vertical scaling");
`endif

endmodule

@@ tb/sv/glyph_span_checker.sv @@
`timescale 1ns / 1ps

module glyph_span_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_full,
    input  tog_pkg::t_char i_char,
    input  logic           i_empty,
    input  logic           i_pop,
    input  tog_pkg::t_span i_span,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic           i_pready,
    input  logic [4:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_chars,
    output int             o_spans
);

    localparam int unsigned FB_STRIDE  = 256;
    localparam int unsigned FB_WIDTH   = 256;
    localparam int unsigned FB_HEIGHT  = 224;
    localparam int unsigned WIDE_ABOVE = 256;
    localparam int unsigned TALL_ABOVE = 224;
    localparam logic [9:0]  POS_LIMIT  = 10'd1023;
    localparam int          BLANK_IDX  = 34;

    localparam logic [8*34-1:0] FONT_CODES = "0123456789ABCDEFGIKLMNOPRSTUVXY=->";

    // shadow of the target registers and the position counter
    logic        tgt_enable;
    logic [31:0] tgt_base;
    logic [12:0] tgt_stride;
    logic [12:0] tgt_width;
    logic [12:0] tgt_height;
    logic [31:0] def_base;
    logic [9:0]  char_pos;

    tog_pkg::t_span span_expect_q[$];
    int fails;
    int chars_seen;
    int spans_seen;

    function automatic int font_index(input logic [7:0] code);
        for (int i = 0; i < 34; i++) begin
            if (FONT_CODES[8*(33-i) +: 8] == code) return i;
        end
        return BLANK_IDX;
    endfunction

    // 7 rows of 5 bits, top row in the high bits, bit 4 of a row = left column
    function automatic logic [34:0] glyph_art(input int idx);
        case (idx)
            0:  return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            1:  return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            2:  return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            3:  return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            4:  return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            5:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            6:  return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            7:  return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8:  return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            9:  return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C};
            10: return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            11: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            12: return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            13: return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            14: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            15: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            16: return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            17: return {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            18: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            19: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            20: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            21: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            22: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            23: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            24: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            25: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            26: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            27: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            28: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            29: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            30: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            31: return {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            32: return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            33: return {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
            default: return '0;
        endcase
    endfunction

    // queue up the spans one character should produce
    task automatic rasterize_char(input tog_pkg::t_char c);
        logic           custom;
        logic [31:0]    base;
        int unsigned    stride, width, height;
        int unsigned    sxf, syf, x0, y;
        logic [9:0]     pos;
        logic [34:0]    art;
        logic [4:0]     bits;
        logic [9:0]     mask;
        int             total, n, col;
        tog_pkg::t_span s;

        custom = tgt_enable && (tgt_stride != 0) && (tgt_width != 0) && (tgt_height != 0);
        base   = custom ? tgt_base : def_base;
        stride = custom ? int'(tgt_stride) : FB_STRIDE;
        width  = custom ? int'(tgt_width)  : FB_WIDTH;
        height = custom ? int'(tgt_height) : FB_HEIGHT;
        sxf    = (width > WIDE_ABOVE) ? 2 : 1;
        syf    = (height > TALL_ABOVE) ? 2 : 1;
        total  = 7 * syf;

        if (c.first_of_string) char_pos = '0;
        pos      = char_pos;
        char_pos = (pos == POS_LIMIT) ? pos : pos + 10'd1;

        x0  = int'(c.start_x) + int'(pos) * 5 * sxf;
        art = glyph_art(font_index(c.char_code));
        n   = 0;
        for (int row = 0; row < 7; row++) begin
            bits = art[5*(6-row) +: 5];
            for (int dy = 0; dy < syf; dy++) begin
                y    = int'(c.start_y) + row * syf + dy;
                mask = '0;
                if (y < height) begin
                    for (int k = 0; k < 5 * sxf; k++) begin
                        col = k / sxf;
                        if (bits[4-col] && (x0 + k < width)) mask[k] = 1'b1;
                    end
                end
                s.span_address = base + y * stride + x0;
                s.write_mask   = mask;
                s.span_color   = c.pen_color;
                s.last_span    = (n == total - 1);
                span_expect_q.push_back(s);
                n++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        tog_pkg::t_span want;
        if (!i_rst_n) begin
            tgt_enable = 1'b0;
            tgt_base   = '0;
            tgt_stride = '0;
            tgt_width  = '0;
            tgt_height = '0;
            def_base   = '0;
            char_pos   = '0;
            span_expect_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    tog_pkg::REG_ENABLE:  tgt_enable = i_pwdata[0];
                    tog_pkg::REG_BASE:    tgt_base   = i_pwdata;
                    tog_pkg::REG_STRIDE:  tgt_stride = i_pwdata[12:0];
                    tog_pkg::REG_WIDTH:   tgt_width  = i_pwdata[12:0];
                    tog_pkg::REG_HEIGHT:  tgt_height = i_pwdata[12:0];
                    tog_pkg::REG_DEFBASE: def_base   = i_pwdata;
                    default: ;
                endcase
            end
            // compare before predicting, so a stray span never meets a fresh entry
            if (i_pop && !i_empty) begin
                spans_seen++;
                if (span_expect_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: span with nothing expected: addr %h mask %h color %h last %b",
                                 $time, i_span.span_address, i_span.write_mask,
                                 i_span.span_color, i_span.last_span);
                end else begin
                    want = span_expect_q.pop_front();
                    if (i_span.span_address !== want.span_address ||
                        i_span.write_mask   !== want.write_mask   ||
                        i_span.span_color   !== want.span_color   ||
                        i_span.last_span    !== want.last_span) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: bad span: addr %h/%h mask %h/%h color %h/%h",
                                      " last %b/%b (expected/actual)"}, $time,
                                     want.span_address, i_span.span_address,
                                     want.write_mask, i_span.write_mask,
                                     want.span_color, i_span.span_color,
                                     want.last_span, i_span.last_span);
                    end
                end
            end
            if (i_push && !i_full) begin
                rasterize_char(i_char);
                chars_seen++;
            end
        end
        o_pending    <= span_expect_q.size();
        o_fail_count <= fails;
        o_chars      <= chars_seen;
        o_spans      <= spans_seen;
    end

endmodule

@@ tb/sv/tb_text_overlay_glyph_rasterizer.sv @@
`timescale 1ns / 1ps

module tb_text_overlay_glyph_rasterizer;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;     // first span passes the job queue, then the output register
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_LEN       = 24;    // long enough that glyphs can run off the right edge

    // addresses past the register list; writes there must change nothing
    localparam logic [2:0] REG_SPARE0 = 3'd6;
    localparam logic [2:0] REG_SPARE1 = 3'd7;

    localparam logic [8*34-1:0] FONT_CODES = "0123456789ABCDEFGIKLMNOPRSTUVXY=->";

    // every block input starts at a known value
    logic           clk     = 1'b0;
    logic           rst_n   = 1'b0;
    logic           push    = 1'b0;
    tog_pkg::t_char char_in = '0;
    logic           pop     = 1'b0;
    logic           psel    = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite  = 1'b0;
    logic [4:0]     paddr   = '0;
    logic [31:0]    pwdata  = '0;

    logic           full;
    logic           empty;
    tog_pkg::t_span span_out;
    logic [31:0]    prdata;
    logic           pready;

    int fail_count;
    int pending;
    int chars_done;
    int spans_done;

    int cycles     = 0;
    int burst_left = 0;   // items left in the current sender burst
    int settings   = 1;   // target settings visited (reset values count as one)
    int hold_reqs  = 0;   // long receiver holds asked for by the stimulus

    always #4 clk = ~clk;

    text_overlay_glyph_rasterizer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .push    (push),
        .full    (full),
        .i_item  (char_in),
        .empty   (empty),
        .pop     (pop),
        .o_span  (span_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glyph_span_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_char       (char_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_span       (span_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars      (chars_done),
        .o_spans      (spans_done)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("text_overlay_glyph_rasterizer: mismatch");
            $finish;
        end
    end

    function automatic tog_pkg::t_char mk_char(input logic [11:0] x, input logic [11:0] y,
                                               input logic [7:0] code,
                                               input logic [15:0] color,
                                               input logic first);
        tog_pkg::t_char c;
        c.start_x         = x;
        c.start_y         = y;
        c.char_code       = code;
        c.pen_color       = color;
        c.first_of_string = first;
        return c;
    endfunction

    // mostly font characters, a quarter of the time any code at all
    function automatic logic [7:0] rand_code();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return FONT_CODES[8*$urandom_range(0, 33) +: 8];
    endfunction

    // mostly on-screen positions, sometimes anywhere in the 12-bit range
    function automatic logic [11:0] rand_coord(input int near);
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return 12'($urandom_range(0, near));
    endfunction

    // register values: full random, small, around the scale thresholds, or zero
    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(1, 300);
            2:       return $urandom_range(200, 300);
            default: return 32'd0;
        endcase
    endfunction

    // Drive one item and hold it until taken. push stays high when the burst
    // goes on, so back-to-back items never see push dropped and raised in one step.
    task automatic send_char(input tog_pkg::t_char c);
        int gap;
        push    <= 1'b1;
        char_in <= c;
        do @(posedge clk); while (full);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 19);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // One string: the first character restarts the position, the rest follow
    // on at the same start point. Noise occasionally flips the restart mark.
    task automatic send_string(input int len, input logic noisy);
        logic [11:0] x;
        logic [11:0] y;
        logic        first;
        x = rand_coord(300);
        y = rand_coord(240);
        for (int i = 0; i < len; i++) begin
            first = (i == 0);
            if (noisy && $urandom_range(0, 15) == 0) first = 1'($urandom_range(0, 1));
            send_char(mk_char(x, y, rand_code(), 16'($urandom), first));
        end
    endtask

    // Stop offering items and wait for every outstanding span to drain.
    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_strings(input int n);
        int left;
        int len;
        left = n;
        while (left > 0) begin
            len = $urandom_range(1, 10);
            if (len > left) len = left;
            send_string(len, 1'b1);
            left -= len;
            // now and then the sender pauses until the block is empty
            if ($urandom_range(0, 7) == 0) settle();
        end
    endtask

    // APB write: setup, then access until pready, then idle with psel low
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: stall pattern in runs of random length. A hold request from the
    // stimulus side freezes pop for a long counted stretch so the block backs up.
    initial begin : rx_side
        int run_left;
        int mode;
        int holds_done;
        run_left   = 0;
        mode       = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_reqs) begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(1, 64);
                end
                run_left--;
                case (mode)
                    0:       pop <= 1'b1;                          // drain flat out
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 4) == 0);   // mostly stalled
                    default: pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- reset target: default buffer, 256x224, no scaling ---
        send_char(mk_char(12'd0, 12'd0, "0", 16'h0000, 1'b1));
        send_char(mk_char(12'd0, 12'd0, "E", 16'hFFFF, 1'b0));
        send_char(mk_char(12'd10, 12'd10, 8'h00, 16'h1234, 1'b0));  // blank codes
        send_char(mk_char(12'd10, 12'd10, 8'hFF, 16'hA5A5, 1'b0));
        send_char(mk_char(12'd100, 12'd50, "=", 16'h5A5A, 1'b1));
        send_char(mk_char(12'd100, 12'd50, "-", 16'h00FF, 1'b0));
        send_char(mk_char(12'd100, 12'd50, ">", 16'hFF00, 1'b0));
        send_char(mk_char(12'd4095, 12'd4095, "8", 16'h8001, 1'b1)); // fully clipped
        send_char(mk_char(12'd252, 12'd20, "M", 16'h7FFE, 1'b1));    // right edge cut
        send_char(mk_char(12'd0, 12'd220, "A", 16'h0F0F, 1'b1));     // bottom edge cut
        send_char(mk_char(12'd4095, 12'd0, "B", 16'hF0F0, 1'b0));
        random_strings(30);

        // --- custom registers loaded but disabled; spare addresses poked ---
        settle();
        cfg_write(REG_SPARE0, $urandom);
        cfg_write(REG_SPARE1, $urandom);
        cfg_write(tog_pkg::REG_DEFBASE, $urandom);
        cfg_write(tog_pkg::REG_BASE, 32'hFFFF_F000);
        cfg_write(tog_pkg::REG_STRIDE, 32'd4096);
        cfg_write(tog_pkg::REG_WIDTH, 32'd4096);
        cfg_write(tog_pkg::REG_HEIGHT, 32'd4096);
        settings++;
        random_strings(30);

        // --- custom target 4096x4096: 2x2 scaling, addresses wrap ---
        settle();
        cfg_write(tog_pkg::REG_ENABLE, 32'd1);
        settings++;
        send_char(mk_char(12'd0, 12'd0, "8", 16'hFFFF, 1'b1));
        send_char(mk_char(12'd4095, 12'd4095, "8", 16'h0001, 1'b1));
        send_char(mk_char(12'd4080, 12'd100, "0", 16'h8000, 1'b0));
        send_char(mk_char(12'd0, 12'd0, 8'hFF, 16'h4321, 1'b0));
        random_strings(20);
        // long receiver hold while the sender keeps pushing: queue fills, full rises
        settle();
        hold_reqs++;
        burst_left = 40;
        send_string(16, 1'b0);
        random_strings(20);

        // --- just over both thresholds, stride from an all-ones write ---
        settle();
        cfg_write(tog_pkg::REG_WIDTH, 32'd257);
        cfg_write(tog_pkg::REG_HEIGHT, 32'd225);
        cfg_write(tog_pkg::REG_STRIDE, 32'hFFFF_FFFF);
        cfg_write(tog_pkg::REG_BASE, 32'd0);
        settings++;
        random_strings(30);

        // --- exactly at the thresholds: no scaling, stride one ---
        settle();
        cfg_write(tog_pkg::REG_WIDTH, 32'd256);
        cfg_write(tog_pkg::REG_HEIGHT, 32'd224);
        cfg_write(tog_pkg::REG_STRIDE, 32'd1);
        cfg_write(tog_pkg::REG_BASE, $urandom);
        settings++;
        random_strings(30);

        // --- one-pixel target: nearly everything clipped ---
        settle();
        cfg_write(tog_pkg::REG_WIDTH, 32'd1);
        cfg_write(tog_pkg::REG_HEIGHT, 32'd1);
        cfg_write(tog_pkg::REG_STRIDE, 32'd4096);
        settings++;
        random_strings(20);

        // --- enabled but height zero: falls back to the default target ---
        settle();
        cfg_write(tog_pkg::REG_HEIGHT, 32'd0);
        settings++;
        random_strings(30);

        // --- a few random settings, fallbacks included ---
        repeat (3) begin
            settle();
            cfg_write(tog_pkg::REG_ENABLE, $urandom);
            cfg_write(tog_pkg::REG_BASE, $urandom);
            cfg_write(tog_pkg::REG_STRIDE, rand_dim());
            cfg_write(tog_pkg::REG_WIDTH, rand_dim());
            cfg_write(tog_pkg::REG_HEIGHT, rand_dim());
            cfg_write(tog_pkg::REG_DEFBASE, $urandom);
            settings++;
            random_strings(20);
        end

        // --- one long string on the default target: glyphs may march off the edge ---
        settle();
        cfg_write(tog_pkg::REG_ENABLE, 32'd0);
        settings++;
        send_string(LONG_LEN, 1'b0);

        // drain, then give stray spans a chance to show up
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d characters, %0d spans over %0d target settings", chars_done,
                 spans_done, settings);
        $display("incl. fallback, blank codes, clipping, 2x scaling, address wrap, long strings");
        if (fail_count == 0) begin
            $display("text_overlay_glyph_rasterizer: match");
        end else begin
            $display("text_overlay_glyph_rasterizer: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tog_pkg.sv
hdl/tog_front.sv
hdl/tog_queue.sv
hdl/tog_back.sv
hdl/text_overlay_glyph_rasterizer.sv
tb/sv/glyph_span_checker.sv
tb/sv/tb_text_overlay_glyph_rasterizer.sv
